[hdl/aes128c_pkg.sv]
`default_nettype none
package aes128c_pkg;

    localparam int unsigned FifoDepth = 4;
    localparam int unsigned PtrW      = $clog2(FifoDepth);
    localparam logic [3:0]  LastRound = 4'd10;
    localparam logic [1:0]  RegKeyHi  = 2'd0;
    localparam logic [1:0]  RegKeyLo  = 2'd1;
    localparam logic [1:0]  RegNonce  = 2'd2;

    // one queued byte: keystream position, and counter when a new block starts
    typedef struct packed {
        logic [7:0]   data;
        logic [3:0]   pos;
        logic         new_blk;
        logic [127:0] ctr;
    } t_entry;

    localparam logic [0:255][7:0] SBOX = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits at bits 127-8i..120-8i
    function automatic logic [127:0] round_fn(input logic [127:0] s, input logic last);
        logic [127:0] t;
        logic [127:0] m;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[127 - 8 * (i + 4 * c) -: 8] = SBOX[s[127 - 8 * (i + 4 * ((c + i) % 4)) -: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[127 - 32 * c -: 8];
            a1 = t[119 - 32 * c -: 8];
            a2 = t[111 - 32 * c -: 8];
            a3 = t[103 - 32 * c -: 8];
            m[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            m[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            m[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            m[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return last ? t : m;
    endfunction

    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rcon);
        logic [31:0] rot;
        logic [31:0] tw;
        logic [31:0] w0, w1, w2, w3;
        rot = {k[23:0], k[31:24]};
        tw  = {SBOX[rot[31:24]] ^ rcon, SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
        w0  = k[127:96] ^ tw;
        w1  = k[95:64] ^ w0;
        w2  = k[63:32] ^ w1;
        w3  = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage
`default_nettype wire

[hdl/aes128c_front.sv]
`default_nettype none
module aes128c_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [7:0]            i_data,
    input  wire logic                  i_restart,
    input  wire logic [63:0]           i_nonce,
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output aes128c_pkg::t_entry        o_entry
);
    logic [127:0] r_ctr, n_ctr;
    logic [3:0]   r_pos, n_pos;
    logic [127:0] ctr_use;
    logic [3:0]   pos_use;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign ctr_use = i_restart ? {i_nonce, 64'd0} : r_ctr;
    assign pos_use = i_restart ? 4'd0 : r_pos;

    always_comb begin
        o_entry.data    = i_data;
        o_entry.pos     = pos_use;
        o_entry.new_blk = (pos_use == 4'd0);
        o_entry.ctr     = ctr_use;
        n_ctr = r_ctr;
        n_pos = r_pos;
        if (o_push) begin
            n_ctr = o_entry.new_blk ? ctr_use + 128'd1 : ctr_use;
            n_pos = pos_use + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
            r_pos <= '0;
        end else begin
            r_ctr <= n_ctr;
            r_pos <= n_pos;
        end
    end
endmodule
`default_nettype wire

[hdl/aes128c_fifo.sv]
`default_nettype none
module aes128c_fifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire aes128c_pkg::t_entry   i_entry,
    output logic                       o_full,
    input  wire logic                  i_pop,
    output logic                       o_valid,
    output aes128c_pkg::t_entry        o_entry
);
    aes128c_pkg::t_entry                r_mem [aes128c_pkg::FifoDepth];
    logic [aes128c_pkg::PtrW-1:0]       r_wr, r_rd;
    logic [aes128c_pkg::PtrW:0]         r_cnt;

    assign o_full  = (r_cnt == (aes128c_pkg::PtrW + 1)'(aes128c_pkg::FifoDepth));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (aes128c_pkg::PtrW + 1)'(i_push) - (aes128c_pkg::PtrW + 1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

[hdl/aes128c_back.sv]
`default_nettype none
module aes128c_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [127:0]          i_key,
    input  wire logic                  i_q_valid,
    input  wire aes128c_pkg::t_entry   i_q_entry,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [7:0]                 o_data
);
    logic [127:0] r_s;
    logic [127:0] r_rk;
    logic [7:0]   r_rcon;
    logic [3:0]   r_rnd;
    logic         r_busy;
    logic         r_done;
    logic         r_ovalid;
    logic [7:0]   r_odata;
    logic         start;
    logic [127:0] rk_next;
    logic         out_free;

    assign out_free = !r_ovalid || i_ready;
    assign start    = i_q_valid && i_q_entry.new_blk && !r_done && !r_busy;
    assign o_pop    = i_q_valid && (!i_q_entry.new_blk || r_done) && out_free;
    assign rk_next  = aes128c_pkg::key_step(r_rk, r_rcon);
    assign o_valid  = r_ovalid;
    assign o_data   = r_odata;

    // iterative round unit, one round per cycle
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_s    <= i_q_entry.ctr ^ i_key;
            r_rk   <= i_key;
            r_rcon <= 8'h01;
        end else if (r_busy) begin
            r_s    <= aes128c_pkg::round_fn(r_s, r_rnd == aes128c_pkg::LastRound) ^ rk_next;
            r_rk   <= rk_next;
            r_rcon <= aes128c_pkg::xtime(r_rcon);
        end
        if (o_pop) begin
            r_odata <= i_q_entry.data ^ r_s[{~i_q_entry.pos, 3'b000} +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd    <= '0;
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (start) begin
                r_busy <= 1'b1;
                r_rnd  <= 4'd1;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 4'd1;
                if (r_rnd == aes128c_pkg::LastRound) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
            if (o_pop && i_q_entry.new_blk) begin
                r_done <= 1'b0;
            end
            if (o_pop) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rnd != 4'd0 && r_rnd <= aes128c_pkg::LastRound))
        else $error("round count out of range");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("block both running and done");
    a_pop_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_q_entry.new_blk) |-> r_done)
        else $error("byte left before keystream ready");
    a_busy_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (i_q_valid && i_q_entry.new_blk))
        else $error("round unit running without a block head");
endmodule
`default_nettype wire

[hdl/aes128_ctr_byte_stream.sv]
// channel     | dir | handshake                        | payload
// s_axis      | in  | i_s_axis_tvalid/o_s_axis_tready  | tdata=data_in, tuser=restart
// m_axis      | out | o_m_axis_tvalid/i_m_axis_tready  | tdata=data_out
// cfg         | in  | i_cfg_valid/o_cfg_ready          | index 0 key_high,1 key_low,2 nonce
// A word whose position is 0 waits for the round unit (load plus ten rounds) before it
// leaves; the other 15 words of a block pass one per cycle unless the output stalls or the queue is empty.
// The single iterative round unit starts a block only once its first word heads the queue.
// Reset is synchronous: counter and position clear, keys and nonce clear.
// A 4-word queue lets input keep flowing while the round unit or the output stalls.
`default_nettype none
module aes128_ctr_byte_stream (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_in
    input  wire logic        i_s_axis_tuser,   // [0] restart
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // [7:0] data_out
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    logic [63:0]         r_key_hi, r_key_lo, r_nonce;
    logic                q_full, q_valid, push, pop;
    aes128c_pkg::t_entry in_entry, head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_nonce  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                aes128c_pkg::RegKeyHi: r_key_hi <= i_cfg_data;
                aes128c_pkg::RegKeyLo: r_key_lo <= i_cfg_data;
                aes128c_pkg::RegNonce: r_nonce  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aes128c_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_data    (i_s_axis_tdata),
        .i_restart (i_s_axis_tuser),
        .i_nonce   (r_nonce),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_entry   (in_entry)
    );

    aes128c_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (in_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (head)
    );

    aes128c_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     ({r_key_hi, r_key_lo}),
        .i_q_valid (q_valid),
        .i_q_entry (head),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata)
    );
endmodule
`default_nettype wire
